### hw/rtl/huff_pkg.sv
// Package for the Huffman code builder: item structs, defaults and field widths.
// No dependencies; every other file imports it.
`default_nettype none
package huff_pkg;
  localparam int DEF_MAX_LEAVES  = 32;
  localparam int DEF_WEIGHT_BITS = 24;
  localparam int IN_WEIGHT_W     = 24;
  localparam int CODE_W          = 31;
  localparam int LEN_W           = 5;
  localparam int QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic [7:0]             symbol;
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        symbol_res;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  code_length;
    logic              last_res;
  } out_item_t;

  // front -> back queue handshake
  typedef struct packed {
    logic valid;
    logic last;
  } q_stat_t;
endpackage
`default_nettype wire

### hw/rtl/huff_front.sv
// Front end: takes leaf items on the start/busy handshake into a two-entry queue.
// Depends on huff_pkg.
`default_nettype none
module huff_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  huff_pkg::in_item_t  in_item,
  input  wire                 pop,
  output huff_pkg::q_stat_t   q_stat,
  output huff_pkg::in_item_t  q_item
);
  import huff_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  in_item_t           q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     cnt_r, cnt_nxt;
  logic               push;

  assign busy   = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign push   = start && !busy;
  assign q_item = q_mem_r[rd_ptr_r];
  assign q_stat = '{valid: (cnt_r != '0), last: q_mem_r[rd_ptr_r].last};

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= in_item;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/huff_back.sv
// Back end: stores leaves, builds the tree by scanned merges, walks each leaf's code.
// Depends on huff_pkg.
`default_nettype none
module huff_back #(
  parameter int MAX_LEAVES  = huff_pkg::DEF_MAX_LEAVES,
  parameter int WEIGHT_BITS = huff_pkg::DEF_WEIGHT_BITS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  huff_pkg::q_stat_t   q_stat,
  input  huff_pkg::in_item_t  q_item,
  output logic                pop,
  output logic                out_valid,
  output huff_pkg::out_item_t out_item
);
  import huff_pkg::*;

  localparam int NODE_COUNT = 2 * MAX_LEAVES - 1;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int LEAF_W     = $clog2(MAX_LEAVES);
  localparam int CNT_W      = $clog2(MAX_LEAVES + 1);
  localparam int SUM_W      = WEIGHT_BITS + $clog2(MAX_LEAVES);
  localparam int TAKE_W     = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_MERGE  = 9'b000000100,
    S_LINK   = 9'b000001000,
    S_WSTART = 9'b000010000,
    S_WCHK   = 9'b000100000,
    S_WPAR   = 9'b001000000,
    S_WLEFT  = 9'b010000000,
    S_WNEXT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SUM_W-1:0] wt_mem  [NODE_COUNT];
  logic [IDX_W-1:0] par_mem [NODE_COUNT];
  logic [IDX_W-1:0] left_mem[NODE_COUNT];
  logic [7:0]       sym_mem [MAX_LEAVES];
  logic [NODE_COUNT-1:0] hp_r;

  logic [SUM_W-1:0] wt_rd_r, wa_r, wb_r;
  logic [IDX_W-1:0] par_rd_r, left_rd_r;
  logic [7:0]       sym_rd_r;
  logic [CNT_W-1:0] cnt_r, n_r;
  logic [IDX_W-1:0] m_r, end_r, j_r, pj_r, a_r, b_r, c_r, p_r;
  logic             pv_r, have_a_r, have_b_r;
  logic [LEAF_W-1:0] i_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  len_r;

  logic             load, store, wt_we, par_we, left_we;
  logic [IDX_W-1:0] wt_wa, par_wa, par_wd;
  logic [SUM_W-1:0] wt_wd, leaf_w;
  logic [CNT_W-1:0] n_new;
  logic             last_leaf;

  always_comb begin
    leaf_w = '0;
    leaf_w[TAKE_W-1:0] = q_item.weight[TAKE_W-1:0];
  end

  assign load  = (state_r == S_IDLE) && q_stat.valid;
  assign pop   = load;
  assign store = load && (cnt_r < CNT_W'(MAX_LEAVES));
  assign n_new = cnt_r + CNT_W'(store);
  assign last_leaf = ((CNT_W'(i_r) + 1'b1) == n_r);

  // memory write ports
  always_comb begin
    wt_we   = store || (state_r == S_MERGE);
    wt_wa   = store ? IDX_W'(cnt_r) : m_r;
    wt_wd   = store ? leaf_w : (wa_r + wb_r);
    par_we  = (state_r == S_MERGE) || (state_r == S_LINK);
    par_wa  = (state_r == S_MERGE) ? a_r : b_r;
    par_wd  = m_r;
    left_we = (state_r == S_MERGE);
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    wt_rd_r <= wt_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd_r <= par_mem[c_r];
  end

  always_ff @(posedge clk) begin
    if (left_we) left_mem[m_r] <= a_r;
    left_rd_r <= left_mem[par_rd_r];
  end

  always_ff @(posedge clk) begin
    if (store) sym_mem[cnt_r[LEAF_W-1:0]] <= q_item.symbol;
    sym_rd_r <= sym_mem[i_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (load && q_stat.last) state_nxt = (n_new == CNT_W'(1)) ? S_WSTART : S_SCAN;
      S_SCAN:   if (j_r == m_r && !pv_r) state_nxt = S_MERGE;
      S_MERGE:  state_nxt = S_LINK;
      S_LINK:   state_nxt = ((m_r + 1'b1) == end_r) ? S_WSTART : S_SCAN;
      S_WSTART: state_nxt = S_WCHK;
      S_WCHK:   state_nxt = (hp_r[c_r] && len_r != LEN_W'(CODE_W)) ? S_WPAR : S_WNEXT;
      S_WPAR:   state_nxt = S_WLEFT;
      S_WLEFT:  state_nxt = S_WCHK;
      S_WNEXT:  state_nxt = last_leaf ? S_IDLE : S_WSTART;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (load && q_stat.last) begin
          n_r      <= n_new;
          m_r      <= IDX_W'(n_new);
          end_r    <= IDX_W'({n_new, 1'b0} - 1'b1);
          hp_r     <= '0;
          j_r      <= '0;
          have_a_r <= 1'b0;
          have_b_r <= 1'b0;
          i_r      <= '0;
        end
      end
      S_SCAN: begin
        if (j_r != m_r) begin
          pj_r <= j_r;
          j_r  <= j_r + 1'b1;
        end
        // compare the entry read last cycle; lower index wins ties
        if (pv_r && !hp_r[pj_r]) begin
          if (!have_a_r || wt_rd_r < wa_r) begin
            b_r <= a_r; wb_r <= wa_r; have_b_r <= have_a_r;
            a_r <= pj_r; wa_r <= wt_rd_r; have_a_r <= 1'b1;
          end else if (!have_b_r || wt_rd_r < wb_r) begin
            b_r <= pj_r; wb_r <= wt_rd_r; have_b_r <= 1'b1;
          end
        end
      end
      S_MERGE: begin
        hp_r[a_r] <= 1'b1;
        hp_r[b_r] <= 1'b1;
      end
      S_LINK: begin
        m_r      <= m_r + 1'b1;
        j_r      <= '0;
        have_a_r <= 1'b0;
        have_b_r <= 1'b0;
      end
      S_WSTART: begin
        c_r    <= IDX_W'(i_r);
        code_r <= '0;
        len_r  <= '0;
      end
      S_WCHK: begin
        if (!(hp_r[c_r] && len_r != LEN_W'(CODE_W))) begin
          out_item.symbol_res  <= sym_rd_r;
          out_item.code        <= code_r;
          out_item.code_length <= len_r;
          out_item.last_res    <= last_leaf;
        end
      end
      S_WPAR: p_r <= par_rd_r;
      S_WLEFT: begin
        if (left_rd_r != c_r) code_r <= code_r | (CODE_W'(1) << len_r);
        len_r <= len_r + 1'b1;
        c_r   <= p_r;
      end
      S_WNEXT: i_r <= i_r + 1'b1;
      default: ;
    endcase
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      pv_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pv_r      <= (state_r == S_SCAN) && (j_r != m_r);
      out_valid <= (state_r == S_WCHK) && !(hp_r[c_r] && len_r != LEN_W'(CODE_W));
      if (load) cnt_r <= q_stat.last ? '0 : n_new;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/huffman_code_builder.sv
// Top level of the Huffman code builder: front queue plus build/walk back end.
// Depends on huff_pkg, huff_front, huff_back.
// Leaves are taken one per cycle while busy is low. The item with last set starts
// the build: n-1 merges, each a scan of the m live-or-dead nodes through the weight
// memory's single read port, then a code walk that climbs from each leaf to the root,
// one code bit per step. One result strobes per leaf for a single cycle, in
// load order, and must be taken then. Two more leaves queue up during a build.
`default_nettype none
module huffman_code_builder #(
  parameter int MAX_LEAVES  = huff_pkg::DEF_MAX_LEAVES,
  parameter int WEIGHT_BITS = huff_pkg::DEF_WEIGHT_BITS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  huff_pkg::in_item_t  in_item,
  output logic                out_valid,
  output huff_pkg::out_item_t out_item
);
  import huff_pkg::*;

  q_stat_t  q_stat;
  in_item_t q_item;
  logic     pop;

  huff_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .pop(pop), .q_stat(q_stat), .q_item(q_item)
  );

  huff_back #(.MAX_LEAVES(MAX_LEAVES), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_stat(q_stat), .q_item(q_item), .pop(pop),
    .out_valid(out_valid), .out_item(out_item)
  );
endmodule
`default_nettype wire

### hw/rtl/huff_checker.sv
// Port-level checks for huffman_code_builder, bound to the top level.
// Depends on huff_pkg.
`default_nettype none
module huff_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input huff_pkg::out_item_t out_item
);
  import huff_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");
  a_code_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.code >> out_item.code_length) == '0))
    else $error("code bits above code_length");
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_res |=> ##1 !out_valid)
    else $error("result right after final leaf");
endmodule

bind huffman_code_builder huff_checker u_huff_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire
